// ===== design/wavosc_pkg.sv =====
// Shared constants and types for the wavetable oscillator.
`timescale 1ns / 1ps

package wavosc_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int OP_W        = 1;
    localparam int IDX_FIELD_W = 10;
    localparam int LEN_W       = 11;
    localparam int STEP_W      = 26;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 26;

    // Item kinds carried in tuser
    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_TICK = 1'b1;

    // Shortest table that produces sound
    localparam int MIN_ACTIVE_LEN = 2;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ENABLE = 2'd0,
        REG_LENGTH = 2'd1,
        REG_STEP   = 2'd2
    } cfg_reg_t;

endpackage

// ===== design/wavetable_oscillator_interp_unit.sv =====
// Wavetable oscillator with linear interpolation between adjacent table entries.
// A tick result passes through v1_reg, v2_reg, v3_reg and out_valid_reg before m_tvalid rises.
// Throughput: one beat per cycle while s_tready is high, loads and ticks mixed, set by the table read pair.
// A write of table_length or phase_step holds s_tready low while the bit-serial
// remainder unit reduces the step modulo the span.
// Reset (aresetn low, synchronous) clears the registers, phase and pipeline valids.
`timescale 1ns / 1ps

module wavetable_oscillator_interp_unit #(
    parameter int TABLE_DEPTH = 1024,
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 16,
    localparam int S_TDATA_W  = ((wavosc_pkg::IDX_FIELD_W + SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [S_TDATA_W-1:0]              s_tdata,  // entry_index, entry_value, zero pad
    input  logic [wavosc_pkg::OP_W-1:0]       s_tuser,  // op
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [M_TDATA_W-1:0]              m_tdata,  // sample, zero pad
    // Configuration writes
    input  logic                              cfg_wr_en,
    input  logic [wavosc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [wavosc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import wavosc_pkg::*;

    localparam int IDX_BITS   = $clog2(TABLE_DEPTH);
    localparam int CLEN_BITS  = $clog2(TABLE_DEPTH + 1);
    localparam int PHASE_BITS = CLEN_BITS + FRAC_BITS;

    // Configuration state
    logic                   enable_reg;
    logic [CLEN_BITS-1:0]   len_reg;
    logic [CLEN_BITS-1:0]   len_clamped;
    logic [STEP_W-1:0]      step_reg;
    logic                   mod_start_reg;
    logic                   mod_busy;
    logic [PHASE_BITS-1:0]  step_mod;

    // Phase accumulator
    logic [PHASE_BITS-1:0]  phase_reg;
    logic [PHASE_BITS-1:0]  phase_next;
    logic [PHASE_BITS-1:0]  span;
    logic [PHASE_BITS:0]    phase_sum;
    logic [PHASE_BITS:0]    span_ext;

    // Beat decode
    logic [IDX_FIELD_W-1:0] entry_index;
    logic [SAMPLE_BITS-1:0] entry_value;
    logic [31:0]            windex_ext;
    logic                   accept;
    logic                   tick_acc;
    logic                   load_acc;
    logic                   load_in_range;
    logic                   silent;

    // Table addressing
    logic [CLEN_BITS-1:0]   idx0;
    logic [CLEN_BITS-1:0]   idx1_inc;
    logic [CLEN_BITS-1:0]   idx1;
    logic [IDX_BITS-1:0]    waddr;
    logic [IDX_BITS-1:0]    raddr0;
    logic [IDX_BITS-1:0]    raddr1;
    logic [SAMPLE_BITS-1:0] rdata0;
    logic [SAMPLE_BITS-1:0] rdata1;

    logic                          ipl_ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    // Unpack the input beat
    assign entry_index = s_tdata[IDX_FIELD_W-1:0];
    assign entry_value = s_tdata[IDX_FIELD_W +: SAMPLE_BITS];

    // Hold off input while the step remainder is being recomputed
    assign s_tready = ipl_ready && !mod_start_reg && !mod_busy;
    assign accept   = s_tvalid && s_tready;
    assign tick_acc = accept && (s_tuser == OP_TICK);
    assign load_acc = accept && (s_tuser == OP_LOAD);

    // Drop loads that fall beyond the physical table
    assign windex_ext    = 32'(entry_index);
    assign load_in_range = windex_ext < 32'(TABLE_DEPTH);
    assign waddr         = windex_ext[IDX_BITS-1:0];

    // Lengths above the table depth act as the full depth
    always_comb begin
        if (32'(cfg_wdata[LEN_W-1:0]) > 32'(TABLE_DEPTH)) begin
            len_clamped = CLEN_BITS'(TABLE_DEPTH);
        end else begin
            len_clamped = CLEN_BITS'(cfg_wdata[LEN_W-1:0]);
        end
    end

    // Register writes; length and step writes kick the remainder unit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b0;
            len_reg       <= '0;
            step_reg      <= '0;
            mod_start_reg <= 1'b0;
        end else begin
            mod_start_reg <= 1'b0;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ENABLE: begin
                        enable_reg <= cfg_wdata[0];
                    end
                    REG_LENGTH: begin
                        len_reg       <= len_clamped;
                        mod_start_reg <= 1'b1;
                    end
                    REG_STEP: begin
                        step_reg      <= cfg_wdata[STEP_W-1:0];
                        mod_start_reg <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign span   = {len_reg, {FRAC_BITS{1'b0}}};
    assign silent = !enable_reg || (32'(len_reg) < 32'(MIN_ACTIVE_LEN));

    // Phase stays below the span, and so does the reduced step: one
    // conditional subtract wraps the sum.
    always_comb begin
        phase_sum = {1'b0, phase_reg} + {1'b0, step_mod};
        span_ext  = {1'b0, span};
        if (phase_sum >= span_ext) begin
            phase_next = PHASE_BITS'(phase_sum - span_ext);
        end else begin
            phase_next = phase_sum[PHASE_BITS-1:0];
        end
    end

    // Clear on a length write, advance on a sounding tick, otherwise hold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (cfg_wr_en && (cfg_addr == REG_LENGTH)) begin
            phase_reg <= '0;
        end else if (tick_acc && !silent) begin
            phase_reg <= phase_next;
        end
    end

    // Integer part of the phase and its successor, wrapping at the length
    always_comb begin
        idx0     = phase_reg[PHASE_BITS-1:FRAC_BITS];
        idx1_inc = idx0 + CLEN_BITS'(1);
        idx1     = (idx1_inc == len_reg) ? '0 : idx1_inc;
        raddr0   = idx0[IDX_BITS-1:0];
        raddr1   = idx1[IDX_BITS-1:0];
    end

    // Two copies of the table give both interpolation taps in one read
    wavosc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table_a (
        .aclk  (aclk),
        .we    (load_acc && load_in_range),
        .waddr (waddr),
        .wdata (entry_value),
        .re    (tick_acc),
        .raddr (raddr0),
        .rdata (rdata0)
    );

    wavosc_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table_b (
        .aclk  (aclk),
        .we    (load_acc && load_in_range),
        .waddr (waddr),
        .wdata (entry_value),
        .re    (tick_acc),
        .raddr (raddr1),
        .rdata (rdata1)
    );

    wavosc_stepmod #(
        .PHASE_BITS (PHASE_BITS)
    ) u_stepmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start_reg),
        .step    (step_reg),
        .span    (span),
        .busy    (mod_busy),
        .rem     (step_mod)
    );

    wavosc_interp #(
        .FRAC_BITS   (FRAC_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_valid  (tick_acc),
        .tick_silent (silent),
        .tick_frac   (phase_reg[FRAC_BITS-1:0]),
        .rd_s0       ($signed(rdata0)),
        .rd_s1       ($signed(rdata1)),
        .in_ready    (ipl_ready),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_sample  (sample)
    );

    assign m_tdata = M_TDATA_W'($unsigned(sample));

endmodule

// ===== design/wavosc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module wavosc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/wavosc_stepmod.sv =====
// Bit-serial remainder unit: reduces the phase step modulo the table span.
`timescale 1ns / 1ps

module wavosc_stepmod #(
    parameter int PHASE_BITS = 27
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [wavosc_pkg::STEP_W-1:0]     step,
    input  logic [PHASE_BITS-1:0]             span,
    output logic                              busy,
    output logic [PHASE_BITS-1:0]             rem
);

    import wavosc_pkg::*;

    localparam int CNT_W = $clog2(STEP_W + 1);

    logic                busy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [STEP_W-1:0]   shift_reg;
    logic [PHASE_BITS-1:0] rem_reg;
    logic [PHASE_BITS:0] trial;
    logic [PHASE_BITS:0] span_ext;
    logic [PHASE_BITS-1:0] rem_next;

    // Shift in one dividend bit, subtract the span when it fits
    always_comb begin
        trial    = {rem_reg, shift_reg[STEP_W-1]};
        span_ext = {1'b0, span};
        if (trial >= span_ext) begin
            rem_next = PHASE_BITS'(trial - span_ext);
        end else begin
            rem_next = trial[PHASE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEP_W);
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= step;
        end else if (busy_reg) begin
            shift_reg <= {shift_reg[STEP_W-2:0], 1'b0};
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// ===== design/wavosc_interp.sv =====
// Interpolation pipeline: difference, multiply by fraction, add, output register.
`timescale 1ns / 1ps

module wavosc_interp #(
    parameter int FRAC_BITS   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          tick_valid,
    input  logic                          tick_silent,
    input  logic [FRAC_BITS-1:0]          tick_frac,
    input  logic signed [SAMPLE_BITS-1:0] rd_s0,
    input  logic signed [SAMPLE_BITS-1:0] rd_s1,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);

    import wavosc_pkg::*;

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

    // Stage 1: table read in flight
    logic                          v1_reg;
    logic                          silent1_reg;
    logic [FRAC_BITS-1:0]          frac1_reg;
    // Stage 2: difference
    logic                          v2_reg;
    logic                          silent2_reg;
    logic signed [SAMPLE_BITS-1:0] s0_2_reg;
    logic signed [DIFF_W-1:0]      diff2_reg;
    logic [FRAC_BITS-1:0]          frac2_reg;
    // Stage 3: product
    logic                          v3_reg;
    logic                          silent3_reg;
    logic signed [SAMPLE_BITS-1:0] s0_3_reg;
    logic signed [PROD_W-1:0]      prod3_reg;
    // Output register
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;

    logic adv_out, en3, en2, en1;
    logic signed [DIFF_W-1:0]      diff_next;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      shifted;
    logic signed [PROD_W-1:0]      sum_full;
    logic signed [SAMPLE_BITS-1:0] out_next;

    // A stage loads when it is empty or its content moves on
    assign adv_out  = !out_valid_reg || out_ready;
    assign en3      = !v3_reg || adv_out;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        diff_next = DIFF_W'(rd_s1) - DIFF_W'(rd_s0);
        prod_next = PROD_W'(diff2_reg) * PROD_W'($signed({1'b0, frac2_reg}));
        shifted   = prod3_reg >>> FRAC_BITS;
        sum_full  = PROD_W'(s0_3_reg) + shifted;
        out_next  = silent3_reg ? '0 : SAMPLE_BITS'(sum_full);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= tick_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (adv_out) begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            silent1_reg <= tick_silent;
            frac1_reg   <= tick_frac;
        end
        if (en2) begin
            silent2_reg <= silent1_reg;
            s0_2_reg    <= rd_s0;
            diff2_reg   <= diff_next;
            frac2_reg   <= frac1_reg;
        end
        if (en3) begin
            silent3_reg <= silent2_reg;
            s0_3_reg    <= s0_2_reg;
            prod3_reg   <= prod_next;
        end
        if (adv_out) begin
            out_sample_reg <= out_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

endmodule
